FILE: rtl/mandelbrot_escape_time_top_assert.svh
`ifndef MANDELBROT_ESCAPE_TIME_TOP_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MBET_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MBET_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: rtl/mbet_pkg.sv
`timescale 1ns / 1ps

package mbet_pkg;

   localparam int WORD_BITS      = 32;
   localparam int PIX_BITS       = 10;
   localparam int COUNT_BITS     = 8;
   localparam int CSR_INDEX_BITS = 3;

   // Escape radius squared is 4, held as its base-two logarithm.
   localparam int ESC_RADIUS_SQ_LOG2 = 2;

   localparam logic [COUNT_BITS-1:0] DEFAULT_LIMIT = 8'd30;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEFT_EDGE      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOP_EDGE       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_X_STEP         = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_Y_STEP         = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_ITERATIONS = 3'd4;

   typedef struct packed {
      logic [PIX_BITS-1:0] pixel_col;
      logic [PIX_BITS-1:0] pixel_row;
   } req_payload_type;

   typedef struct packed {
      logic [PIX_BITS-1:0]   out_col;
      logic [PIX_BITS-1:0]   out_row;
      logic [COUNT_BITS-1:0] iteration_count;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture the pixel coordinate
      logic map;       // form c and clear z and the count
      logic mul;       // register the three products of z
      logic update;    // take the next z and bump the count
      logic out_load;  // move the finished result to the output register
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic at_limit;  // count has reached the iteration limit
      logic escaped;   // |z|^2 is at or beyond the escape radius squared
   } dp_status_type;

endpackage

FILE: rtl/mbet_datapath.sv
`timescale 1ns / 1ps

module mbet_datapath import mbet_pkg::*; #(
   parameter int COORD_BITS = 10,
   parameter int FRAC_BITS  = 28
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [WORD_BITS-1:0]          csr_wdata,
   input  req_payload_type               req_data,
   input  dp_cmd_type                    cmd,
   output dp_status_type                 status,
   output rsp_payload_type               rsp_data
);

   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam logic [PIX_BITS-1:0] COORD_MASK = (COORD_BITS >= PIX_BITS) ?
      {PIX_BITS{1'b1}} : PIX_BITS'((64'd1 << COORD_BITS) - 64'd1);
   localparam int ESC_SHIFT      = 2 * FRAC_BITS + ESC_RADIUS_SQ_LOG2;
   localparam bit NO_ESCAPE      = (ESC_SHIFT >= PROD_BITS);
   localparam int ESC_SHIFT_SAFE = NO_ESCAPE ? 0 : ESC_SHIFT;
   localparam logic [PROD_BITS-1:0] ESC_LIMIT =
      {{(PROD_BITS-1){1'b0}}, 1'b1} << ESC_SHIFT_SAFE;

   // Configuration registers.
   logic signed [WORD_BITS-1:0] left_edge_ff, top_edge_ff, x_step_ff, y_step_ff;
   logic [COUNT_BITS-1:0]       max_iter_ff;

   // Working registers.
   logic [PIX_BITS-1:0]          x_ff, y_ff;
   logic signed [WORD_BITS-1:0]  c_re_ff, c_im_ff, z_re_ff, z_im_ff;
   logic signed [PROD_BITS-1:0]  rr_ff, ii_ff, ri_ff;
   logic [COUNT_BITS-1:0]        count_ff;
   rsp_payload_type              rsp_ff;

   logic signed [PIX_BITS+WORD_BITS:0] map_re_prod, map_im_prod;
   logic signed [WORD_BITS-1:0]        c_re_in, c_im_in, z_re_in, z_im_in;
   logic signed [PROD_BITS-1:0]        rr_in, ii_in, ri_in;
   logic signed [PROD_BITS-1:0]        rr_sh, ii_sh, ri_sh;
   logic [PROD_BITS-1:0]               mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_edge_ff <= '0;
         top_edge_ff  <= '0;
         x_step_ff    <= '0;
         y_step_ff    <= '0;
         max_iter_ff  <= DEFAULT_LIMIT;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LEFT_EDGE:      left_edge_ff <= csr_wdata;
            CSR_TOP_EDGE:       top_edge_ff  <= csr_wdata;
            CSR_X_STEP:         x_step_ff    <= csr_wdata;
            CSR_Y_STEP:         y_step_ff    <= csr_wdata;
            CSR_MAX_ITERATIONS: max_iter_ff  <= csr_wdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Pixel to point: only the low word of step*pixel matters after wrapping.
   assign map_re_prod = $signed({1'b0, x_ff}) * x_step_ff;
   assign map_im_prod = $signed({1'b0, y_ff}) * y_step_ff;
   assign c_re_in = map_re_prod[WORD_BITS-1:0] + left_edge_ff;
   assign c_im_in = map_im_prod[WORD_BITS-1:0] + top_edge_ff;

   assign rr_in = z_re_ff * z_re_ff;
   assign ii_in = z_im_ff * z_im_ff;
   assign ri_in = z_re_ff * z_im_ff;

   // Truncating shifts; the cross term is doubled by shifting one less.
   assign rr_sh = rr_ff >>> FRAC_BITS;
   assign ii_sh = ii_ff >>> FRAC_BITS;
   assign ri_sh = ri_ff >>> (FRAC_BITS - 1);
   assign z_re_in = rr_sh[WORD_BITS-1:0] - ii_sh[WORD_BITS-1:0] + c_re_ff;
   assign z_im_in = ri_sh[WORD_BITS-1:0] + c_im_ff;

   // Both squares are at most 2^62, so the sum cannot overflow 64 bits.
   assign mag = rr_ff + ii_ff;

   assign status.escaped  = !NO_ESCAPE && (mag >= ESC_LIMIT);
   assign status.at_limit = (count_ff >= max_iter_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= req_data.pixel_col & COORD_MASK;
         y_ff <= req_data.pixel_row & COORD_MASK;
      end
      if (cmd.map) begin
         c_re_ff  <= c_re_in;
         c_im_ff  <= c_im_in;
         z_re_ff  <= '0;
         z_im_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.update) begin
         z_re_ff  <= z_re_in;
         z_im_ff  <= z_im_in;
         count_ff <= count_ff + 1'b1;
      end
      if (cmd.mul) begin
         rr_ff <= rr_in;
         ii_ff <= ii_in;
         ri_ff <= ri_in;
      end
      if (cmd.out_load) begin
         rsp_ff.out_col         <= x_ff;
         rsp_ff.out_row         <= y_ff;
         rsp_ff.iteration_count <= count_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: rtl/mbet_controller.sv
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_top_assert.svh"

module mbet_controller import mbet_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_MUL,
      ST_UPD,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_fire, out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            cmd.map  = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (status.at_limit) begin
               state_in = ST_DONE;
            end else begin
               cmd.mul  = 1'b1;
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (status.escaped) begin
               state_in = ST_DONE;
            end else begin
               cmd.update = 1'b1;
               state_in   = ST_MUL;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `MBET_ASSERT_NXT(a_accept_maps, clock, reset, req_fire, state_ff == ST_MAP)
   `MBET_ASSERT_NXT(a_map_then_mul, clock, reset, state_ff == ST_MAP, state_ff == ST_MUL)
   `MBET_ASSERT_IMP(a_no_overwrite, clock, reset, cmd.out_load, !(rsp_valid_ff && rsp_stall))
   `MBET_ASSERT_NXT(a_limit_ends, clock, reset, (state_ff == ST_MUL) && status.at_limit,
                    state_ff == ST_DONE)

endmodule

FILE: rtl/mandelbrot_escape_time_top.sv
// An accepted transaction goes through the map step, then alternating multiply and update
// steps, ending at a multiply step on the limit or at an update step when the point escapes;
// the done state then waits until the output register is free. Throughput: one pixel at a
// time, and an iteration is one multiply step and one update step.
// Reset (synchronous, active high) idles the controller, drops rsp_valid, clears the edges
// and steps to zero and sets the iteration limit to 30.
`timescale 1ns / 1ps

module mandelbrot_escape_time_top import mbet_pkg::*; #(
   parameter int COORD_BITS = 10,
   parameter int FRAC_BITS  = 28
) (
   input  logic                      clock,
   input  logic                      reset,
   // Configuration write port.
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [WORD_BITS-1:0]      csr_wdata,
   // Pixel request channel.
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_payload_type           req_data,
   // Result channel.
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_payload_type           rsp_data
);

   // The controller sequences one pixel through map, multiply and update
   // steps; the datapath holds the configuration, the point c, the running
   // value z, the three 32x32 products and the iteration count.
   dp_cmd_type    cmd;
   dp_status_type status;

   // A finished result sits in the datapath's output register, so a new
   // transaction is accepted while the previous result still waits to be taken.
   mbet_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mbet_datapath #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import mbet_pkg::*;

   // Fraction bits of the fixed point format, shared by the block and the predictor.
   localparam int FRAC_BITS = 28;

   // The escape test compares |z|^2 in full width against 4 at the scale of a product.
   localparam int ESCAPE_SHIFT = ESC_RADIUS_SQ_LOG2 + 2 * FRAC_BITS;
   localparam bit NEVER_ESCAPES = (ESCAPE_SHIFT >= 64);
   localparam bit [63:0] ESCAPE_BOUND = NEVER_ESCAPES ? 64'd0 : (64'd1 << ESCAPE_SHIFT);

   // Index 5 maps to no register; writes to it must leave every setting alone.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd5;

   localparam logic [PIX_BITS-1:0] PIX_MAX = '1;

   // A view of the whole set: real part from -2.5 over 3.5, imaginary part from -1.25
   // over 2.5, spread across 1024 columns and rows.
   localparam int VIEW_LEFT   = -671088640;
   localparam int VIEW_TOP    = -335544320;
   localparam int VIEW_X_STEP = 917504;
   localparam int VIEW_Y_STEP = 655360;

   localparam int ITEM_TARGET = 1750;
   localparam int HOLD_CYCLES = 700;
   // Longest legal run of a single pixel, used as the settling time at the end.
   localparam int TAIL_CYCLES = 2 * 255 + 4;
   // No transaction for this many cycles means the block has hung.
   localparam int QUIET_LIMIT = 4000;

   // Holds the expected results in order and a copy of the configuration registers.
   class pixel_scoreboard;
      int left_edge;
      int top_edge;
      int x_step;
      int y_step;
      bit [COUNT_BITS-1:0] iter_limit;
      rsp_payload_type expected_q[$];
      int mismatches;

      function new();
         left_edge  = 0;
         top_edge   = 0;
         x_step     = 0;
         y_step     = 0;
         iter_limit = DEFAULT_LIMIT;
         mismatches = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [WORD_BITS-1:0] data);
         case (index)
            CSR_LEFT_EDGE:      left_edge  = data;
            CSR_TOP_EDGE:       top_edge   = data;
            CSR_X_STEP:         x_step     = data;
            CSR_Y_STEP:         y_step     = data;
            CSR_MAX_ITERATIONS: iter_limit = data[COUNT_BITS-1:0];
            default: ;
         endcase
      endfunction

      // Maps the pixel to c and counts iterations of z = z*z + c until escape or limit.
      function rsp_payload_type escape_time(req_payload_type px);
         longint col;
         longint row;
         int c_re;
         int c_im;
         int z_re;
         int z_im;
         longint re_sq;
         longint im_sq;
         longint cross_term;
         bit [63:0] magnitude;
         int steps;
         rsp_payload_type res;
         col   = px.pixel_col;
         row   = px.pixel_row;
         // The mapping wraps to 32 bits when the point leaves the word range.
         c_re  = int'(col * x_step + left_edge);
         c_im  = int'(row * y_step + top_edge);
         z_re  = 0;
         z_im  = 0;
         steps = 0;
         while (steps < iter_limit) begin
            re_sq      = longint'(z_re) * longint'(z_re);
            im_sq      = longint'(z_im) * longint'(z_im);
            cross_term = longint'(z_re) * longint'(z_im);
            magnitude  = re_sq + im_sq;
            if (!NEVER_ESCAPES && magnitude >= ESCAPE_BOUND)
               break;
            z_re  = int'((re_sq >>> FRAC_BITS) - (im_sq >>> FRAC_BITS) + c_re);
            // Doubling the cross term is folded into a shift that is one bit shorter.
            z_im  = int'((cross_term >>> (FRAC_BITS - 1)) + c_im);
            steps++;
         end
         res.out_col         = px.pixel_col;
         res.out_row         = px.pixel_row;
         res.iteration_count = steps[COUNT_BITS-1:0];
         return res;
      endfunction

      function void note_pixel(req_payload_type px);
         expected_q.push_back(escape_time(px));
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result col %0d row %0d count %0d",
                        got.out_col, got.out_row, got.iteration_count);
            return;
         end
         want = expected_q.pop_front();
         if (got.out_col !== want.out_col || got.out_row !== want.out_row ||
             got.iteration_count !== want.iteration_count) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: expected col %0d row %0d count %0d, got col %0d row %0d count %0d",
                        want.out_col, want.out_row, want.iteration_count,
                        got.out_col, got.out_row, got.iteration_count);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [WORD_BITS-1:0]      csr_wdata = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_payload_type           req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_payload_type           rsp_data;

   pixel_scoreboard sb = new();

   // Pixels accepted so far; no new random phase starts once this reaches the target.
   int items_sent = 0;
   // While set, neither side inserts random idle cycles.
   bit calm = 1'b0;
   // Asks the result side for one long hold-off.
   bit hold_wanted = 1'b0;

   mandelbrot_escape_time_top #(
      .COORD_BITS(PIX_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // One register write. The prediction takes the new value once the write edge has passed.
   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [WORD_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_register(index, data);
   endtask

   // Programs the whole view. The block must be idle when this is called. The limit is
   // written with random upper bits, which the block must ignore, and every setup ends
   // with a write to the unused index so that the next pixels show it did no harm.
   task automatic program_view(input int left, input int top, input int xs, input int ys,
                               input logic [COUNT_BITS-1:0] lim);
      write_register(CSR_LEFT_EDGE, left);
      write_register(CSR_TOP_EDGE, top);
      write_register(CSR_X_STEP, xs);
      write_register(CSR_Y_STEP, ys);
      write_register(CSR_MAX_ITERATIONS, {24'($urandom()), lim});
      write_register(CSR_UNUSED, $urandom());
      csr_wr_en <= 1'b0;
   endtask

   // Offers one pixel and returns on the edge at which the transaction is accepted.
   // Valid stays high on return so that back-to-back pixels never drop it for a step.
   task automatic send_pixel(input logic [PIX_BITS-1:0] col, input logic [PIX_BITS-1:0] row);
      req_payload_type px;
      px.pixel_col = col;
      px.pixel_row = row;
      while (!calm && $urandom_range(0, 99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_pixel(px);
      items_sent++;
   endtask

   // Stops offering pixels and waits until every expected result has arrived. The
   // queue is polled on the falling edge, away from the edge where results are taken.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   // Result side: checks each accepted transaction and chooses the stall for the next
   // cycle. One long hold-off lets the block fill up and push back on its input.
   initial begin : result_sink
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_result(rsp_data);
         if (hold_wanted && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 18);
         end
      end
   end

   // Ends the run when neither channel has moved a transaction for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("ERROR: no transaction for %0d cycles", QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      int phase;
      int n;
      int kind;
      int left;
      int top;
      int xs;
      int ys;
      logic [COUNT_BITS-1:0] lim;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings put c at zero for every pixel, so each one runs to the default
      // limit. The four corners drive every coordinate bit both ways.
      send_pixel(0, 0);
      send_pixel(PIX_MAX, PIX_MAX);
      send_pixel(0, PIX_MAX);
      send_pixel(PIX_MAX, 0);
      drain();

      // The full view at the default limit: corners escape at once, the pixel near
      // the origin stays inside, the rest land in between.
      program_view(VIEW_LEFT, VIEW_TOP, VIEW_X_STEP, VIEW_Y_STEP, DEFAULT_LIMIT);
      send_pixel(0, 0);
      send_pixel(PIX_MAX, PIX_MAX);
      send_pixel(731, 512);
      send_pixel(256, 512);
      send_pixel(512, 300);
      send_pixel(600, 700);
      drain();

      // A zero limit must give a count of zero without any iteration.
      program_view(VIEW_LEFT, VIEW_TOP, VIEW_X_STEP, VIEW_Y_STEP, 8'd0);
      send_pixel(731, 512);
      send_pixel(0, 0);
      drain();

      program_view(VIEW_LEFT, VIEW_TOP, VIEW_X_STEP, VIEW_Y_STEP, 8'd1);
      send_pixel(731, 512);
      send_pixel(0, 0);
      drain();

      // The largest limit, with one pixel that never escapes.
      program_view(VIEW_LEFT, VIEW_TOP, VIEW_X_STEP, VIEW_Y_STEP, 8'd255);
      send_pixel(731, 512);
      send_pixel(0, 0);
      drain();

      // Extreme edges and steps, where the mapped point wraps around the word.
      program_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, DEFAULT_LIMIT);
      send_pixel(PIX_MAX, PIX_MAX);
      send_pixel(1, 1);
      send_pixel(0, 0);
      drain();

      program_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 8'd255);
      send_pixel(PIX_MAX, 0);
      send_pixel(0, PIX_MAX);

      // Random phases, each with its own view and limit. Most views sit on the
      // interesting part of the set so that the counts spread out; the rest are
      // fully random words.
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         drain();
         kind = $urandom_range(0, 99);
         if (kind < 80) begin
            xs = $urandom_range(16, 1 << 20);
            ys = $urandom_range(16, 1 << 20);
            if ($urandom_range(0, 3) == 0)
               xs = -xs;
            if ($urandom_range(0, 3) == 0)
               ys = -ys;
            left = int'($urandom_range(0, 671088640)) - 536870912 - 512 * xs;
            top  = int'($urandom_range(0, 671088640)) - 335544320 - 512 * ys;
         end else begin
            left = $urandom();
            top  = $urandom();
            xs   = $urandom();
            ys   = $urandom();
         end
         kind = $urandom_range(0, 99);
         if (kind < 70)
            lim = COUNT_BITS'($urandom_range(1, 64));
         else if (kind < 85)
            lim = COUNT_BITS'($urandom_range(65, 255));
         else if (kind < 93)
            lim = 8'd255;
         else
            lim = COUNT_BITS'($urandom_range(0, 1));
         // Long limits make pixels slow, so those phases stay short.
         n = (lim > 100) ? $urandom_range(15, 30) : $urandom_range(40, 100);
         program_view(left, top, xs, ys, lim);

         // One phase runs without any idle cycles on either side, and one starts
         // with the result side held off while pixels keep coming.
         calm = (phase == 3);
         if (phase == 1)
            hold_wanted = 1'b1;

         for (int i = 0; i < n; i++) begin
            // Halfway through one phase, the sender waits for the block to empty.
            if (phase == 5 && i == n / 2)
               drain();
            send_pixel(PIX_BITS'($urandom_range(0, PIX_MAX)),
                       PIX_BITS'($urandom_range(0, PIX_MAX)));
         end
         phase++;
      end

      drain();
      calm = 1'b0;
      // Any stray result would show up within the longest pixel time.
      repeat (TAIL_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
